>>> hw/rtl/brf_pkg.sv
// Shared types, constants and helper functions for the circular byte FIFO.
// No dependencies; every other file in this folder imports it.
package brf_pkg;

  // Store geometry and burst limit.
  localparam int DEPTH      = 1024;
  localparam int READ_BURST = 64;
  localparam int AW         = $clog2(DEPTH);           // store address width
  localparam int CW         = 11;                      // count and level width
  localparam int BW         = $clog2(READ_BURST + 1);  // burst counter width

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] BURST_C = CW'(READ_BURST);

  // Request opcodes.
  typedef enum logic [2:0] {
    CMD_WRITE   = 3'd0,
    CMD_READ    = 3'd1,
    CMD_DISCARD = 3'd2,
    CMD_REWIND  = 3'd3,
    CMD_DROP    = 3'd4,
    CMD_FLUSH   = 3'd5,
    CMD_SEARCH  = 3'd6
  } cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEARCH
  } state_t;

  // One request.
  typedef struct packed {
    logic [2:0]    command;
    logic [7:0]    data_byte;
    logic [CW-1:0] count;
  } in_t;

  // One result.
  typedef struct packed {
    logic [7:0]    data_out;
    logic          byte_valid;
    logic          last;
    logic [CW-1:0] amount;
    logic          found;
    logic [CW-1:0] fill_level;
    logic          is_empty;
    logic          is_full;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // request taken this cycle
    logic rd_issue;   // read one byte of a burst
    logic sr_issue;   // fetch the next byte of a search
    logic sr_report;  // search finished, emit its result
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic go_read;    // offered request is a read burst of one byte or more
    logic go_search;  // offered request is a search over a non-empty FIFO
    logic rd_last;    // the burst byte being issued is the final one
    logic sr_done;    // the compared byte ends the search
  } sts_t;

  // Capacity saturated to the range one to DEPTH.
  function automatic logic [CW-1:0] sat_cap(input logic [CW-1:0] v);
    logic [CW-1:0] c;
    c = v;
    if (c == '0) c = CW'(1);
    if (c > DEPTH_C) c = DEPTH_C;
    return c;
  endfunction

  // Advance a position by one, wrapping at the capacity.
  function automatic logic [AW-1:0] bump(input logic [AW-1:0] pos,
                                         input logic [CW-1:0] cap);
    logic [CW-1:0] p1;
    p1 = CW'(pos) + CW'(1);
    return (p1 >= cap) ? '0 : p1[AW-1:0];
  endfunction

endpackage

>>> hw/rtl/brf_ctrl.sv
// Controller state machine for the circular byte FIFO.
// Depends on brf_pkg; drives the datapath through ctl_t and watches sts_t.
module brf_ctrl
  import brf_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   start,
  output logic   busy,
  input  sts_t   sts,
  output ctl_t   ctl
);

  state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state: bursts and searches hold the controller, all else leaves it idle.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start && sts.go_read) begin
          state_nxt = ST_READ;
        end else if (start && sts.go_search) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_READ: begin
        if (sts.rd_last) state_nxt = ST_IDLE;
      end
      ST_SEARCH: begin
        if (sts.sr_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    ctl  = '0;
    busy = 1'b1;
    case (state_r)
      ST_IDLE: begin
        busy     = 1'b0;
        ctl.load = start;
      end
      ST_READ: begin
        ctl.rd_issue = 1'b1;
      end
      ST_SEARCH: begin
        ctl.sr_report = sts.sr_done;
        ctl.sr_issue  = !sts.sr_done;
      end
      default: busy = 1'b1;
    endcase
  end

  // A burst or search is only entered from idle on a taken request.
  a_enter_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && state_nxt != ST_IDLE) |-> start)
    else $error("busy state entered without a request");

  // Only one datapath command is raised in a cycle.
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctl.load, ctl.rd_issue, ctl.sr_issue, ctl.sr_report}))
    else $error("conflicting datapath commands");

  // A request is never taken while busy.
  a_no_load_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !ctl.load)
    else $error("request taken while busy");

endmodule

>>> hw/rtl/brf_dp.sv
// Datapath of the circular byte FIFO: byte store, positions, fill level,
// burst and search counters and the result register. Depends on brf_pkg.
module brf_dp
  import brf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  in_t           in_req,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata,
  input  ctl_t          ctl,
  output sts_t          sts,
  output logic          out_strobe,
  output out_t          out_res
);

  // Byte store, no reset.
  logic [7:0] mem [DEPTH];
  logic [7:0] mem_q;

  logic [CW-1:0] cap_r, cap_nxt;
  logic [AW-1:0] rpos_r, rpos_nxt;
  logic [AW-1:0] wpos_r, wpos_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [BW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [7:0]    key_r, key_nxt;
  logic [AW-1:0] spos_r, spos_nxt;
  logic [CW-1:0] issue_idx_r, issue_idx_nxt;
  logic [CW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic          cmp_valid_r, cmp_valid_nxt;
  out_t          out_r, out_nxt;
  logic          out_stb_r, out_stb_nxt;
  logic          byte_sel_r, byte_sel_nxt;

  logic          mem_we;
  logic [AW-1:0] rd_addr;

  // Request decode helpers.
  logic [CW-1:0] cnt_fill_min;
  logic [CW-1:0] rd_n;
  logic [CW-1:0] free_sp;
  logic [CW-1:0] rew_n;
  logic [CW-1:0] disc_pos;
  logic          sr_hit;

  always_comb begin
    cnt_fill_min = (in_req.count < fill_r) ? in_req.count : fill_r;
    rd_n         = (cnt_fill_min > BURST_C) ? BURST_C : cnt_fill_min;
    free_sp      = cap_r - fill_r;
    rew_n        = (in_req.count < free_sp) ? in_req.count : free_sp;
    disc_pos     = CW'(rpos_r) + cnt_fill_min;
    if (disc_pos >= cap_r) disc_pos = disc_pos - cap_r;
    sr_hit       = cmp_valid_r && (mem_q == key_r);
  end

  // Status for the controller.
  always_comb begin
    sts.go_read   = (cmd_t'(in_req.command) == CMD_READ) && (rd_n != '0);
    sts.go_search = (cmd_t'(in_req.command) == CMD_SEARCH) && (fill_r != '0);
    sts.rd_last   = (rem_r == BW'(1));
    sts.sr_done   = cmp_valid_r && (sr_hit || (cmp_idx_r == fill_r - CW'(1)));
  end

  // Next-state logic for positions, counters and the result.
  always_comb begin
    cap_nxt       = cap_r;
    rpos_nxt      = rpos_r;
    wpos_nxt      = wpos_r;
    fill_nxt      = fill_r;
    rem_nxt       = rem_r;
    n_nxt         = n_r;
    key_nxt       = key_r;
    spos_nxt      = spos_r;
    issue_idx_nxt = issue_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    cmp_valid_nxt = cmp_valid_r;
    out_stb_nxt   = 1'b0;
    byte_sel_nxt  = 1'b0;
    mem_we        = 1'b0;
    out_nxt       = '0;
    out_nxt.last  = 1'b1;

    if (ctl.load) begin
      out_stb_nxt = 1'b1;
      case (cmd_t'(in_req.command))
        CMD_WRITE: begin
          if (fill_r < cap_r) begin
            mem_we         = 1'b1;
            wpos_nxt       = bump(wpos_r, cap_r);
            fill_nxt       = fill_r + CW'(1);
            out_nxt.amount = CW'(1);
          end
        end
        CMD_READ: begin
          // A non-empty burst reports from the burst cycles instead.
          if (rd_n != '0) begin
            out_stb_nxt = 1'b0;
            fill_nxt    = fill_r - rd_n;
            n_nxt       = rd_n;
            rem_nxt     = rd_n[BW-1:0];
          end
        end
        CMD_DISCARD: begin
          rpos_nxt       = disc_pos[AW-1:0];
          fill_nxt       = fill_r - cnt_fill_min;
          out_nxt.amount = cnt_fill_min;
        end
        CMD_REWIND: begin
          if (CW'(rpos_r) < rew_n) begin
            rpos_nxt = AW'(CW'(rpos_r) + cap_r - rew_n);
          end else begin
            rpos_nxt = AW'(CW'(rpos_r) - rew_n);
          end
          fill_nxt       = fill_r + rew_n;
          out_nxt.amount = rew_n;
        end
        CMD_DROP: begin
          if (fill_r > in_req.count) begin
            if (CW'(wpos_r) < in_req.count) begin
              wpos_nxt = AW'(CW'(wpos_r) + cap_r - in_req.count);
            end else begin
              wpos_nxt = AW'(CW'(wpos_r) - in_req.count);
            end
            fill_nxt       = fill_r - in_req.count;
            out_nxt.amount = in_req.count;
          end else begin
            rpos_nxt       = '0;
            wpos_nxt       = '0;
            fill_nxt       = '0;
            out_nxt.amount = fill_r;
          end
        end
        CMD_FLUSH: begin
          rpos_nxt       = '0;
          wpos_nxt       = '0;
          fill_nxt       = '0;
          out_nxt.amount = fill_r;
        end
        CMD_SEARCH: begin
          // An empty FIFO misses at once; otherwise walk from the read position.
          if (fill_r != '0) begin
            out_stb_nxt   = 1'b0;
            key_nxt       = in_req.data_byte;
            spos_nxt      = rpos_r;
            issue_idx_nxt = '0;
            cmp_valid_nxt = 1'b0;
          end
        end
        default: begin
          out_nxt.amount = '0;
        end
      endcase
    end

    // One byte of a read burst: data comes back from the store next cycle.
    if (ctl.rd_issue) begin
      rpos_nxt           = bump(rpos_r, cap_r);
      rem_nxt            = rem_r - BW'(1);
      out_stb_nxt        = 1'b1;
      byte_sel_nxt       = 1'b1;
      out_nxt.byte_valid = 1'b1;
      out_nxt.last       = (rem_r == BW'(1));
      out_nxt.amount     = n_r;
    end

    // Search: fetch one byte a cycle, compare it the cycle after.
    if (ctl.sr_issue) begin
      spos_nxt      = bump(spos_r, cap_r);
      cmp_idx_nxt   = issue_idx_r;
      issue_idx_nxt = issue_idx_r + CW'(1);
      cmp_valid_nxt = 1'b1;
    end

    if (ctl.sr_report) begin
      out_stb_nxt    = 1'b1;
      out_nxt.found  = sr_hit;
      out_nxt.amount = sr_hit ? cmp_idx_r : '0;
      cmp_valid_nxt  = 1'b0;
    end

    // Level flags always describe the level after the request.
    out_nxt.fill_level = fill_nxt;
    out_nxt.is_empty   = (fill_nxt == '0);
    out_nxt.is_full    = (fill_nxt == cap_r);

    // Writing the capacity also empties the FIFO.
    if (cfg_we) begin
      cap_nxt  = sat_cap(cfg_wdata);
      rpos_nxt = '0;
      wpos_nxt = '0;
      fill_nxt = '0;
    end
  end

  // Store write and registered read.
  assign rd_addr = ctl.rd_issue ? rpos_r : spos_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wpos_r] <= in_req.data_byte;
    end
    mem_q <= mem[rd_addr];
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= DEPTH_C;
      rpos_r      <= '0;
      wpos_r      <= '0;
      fill_r      <= '0;
      rem_r       <= '0;
      cmp_valid_r <= 1'b0;
      out_stb_r   <= 1'b0;
      byte_sel_r  <= 1'b0;
    end else begin
      cap_r       <= cap_nxt;
      rpos_r      <= rpos_nxt;
      wpos_r      <= wpos_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_stb_r   <= out_stb_nxt;
      byte_sel_r  <= byte_sel_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    n_r         <= n_nxt;
    key_r       <= key_nxt;
    spos_r      <= spos_nxt;
    issue_idx_r <= issue_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    out_r       <= out_nxt;
  end

  // Result port: a burst byte is taken straight from the store read register.
  always_comb begin
    out_res          = out_r;
    out_res.data_out = byte_sel_r ? mem_q : 8'h00;
  end
  assign out_strobe = out_stb_r;

  // The level never exceeds the capacity in use.
  a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= cap_r)
    else $error("fill level above capacity");

  // Both positions stay inside the part of the store in use.
  a_pos_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (CW'(rpos_r) < cap_r) && (CW'(wpos_r) < cap_r))
    else $error("position outside capacity");

  // A burst byte is only issued while bytes remain.
  a_burst_rem: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_issue |-> (rem_r != '0))
    else $error("burst issued past its length");

  // A burst is delivered without gaps up to its last byte.
  a_burst_gapless: assert property (@(posedge clk) disable iff (!rst_n)
    (out_stb_r && !out_r.last) |=> (out_stb_r && byte_sel_r))
    else $error("gap inside a read burst");

endmodule

>>> hw/rtl/byte_ring_fifo.sv
// Top level of the circular byte FIFO: controller plus datapath.
// Depends on brf_pkg, brf_ctrl and brf_dp.
//
// Usage. A request (in_req: command, data_byte, count) is taken on a clock
// edge with start high and busy low. Results leave on out_res, each valid for
// exactly one cycle while out_strobe is high; the receiver cannot stall them
// and must take every strobed result. The user must write the capacity
// register (cfg_we with cfg_wdata) only while the block is idle; the block does
// not enforce this itself. The write also empties the FIFO. By request kind:
//  - write, discard, rewind, drop tail, flush, an empty read and a search of an
//    empty FIFO: one result in the cycle after the request; busy stays low, so
//    one such request can be taken every cycle.
//  - read burst of n bytes (n up to 64): n results with no gap, the first from
//    the store read register; busy while the bytes are issued. Rate is one byte a
//    cycle, set by the single read port of the byte store.
//  - search: one store byte compared per cycle, each read through the store read
//    register; a hit reports once its byte is compared, a miss once the last
//    stored byte is; busy until the cycle before the result.
// Reset (rst_n low at a clock edge) empties the FIFO and sets the capacity to
// 1024; the store contents are not cleared and need no clearing pass.
module byte_ring_fifo
  import brf_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  in_t           in_req,
  input  logic          cfg_we,
  input  logic [CW-1:0] cfg_wdata,
  output logic          out_strobe,
  output out_t          out_res
);

  ctl_t ctl;
  sts_t sts;

  // Sequencing of bursts and searches.
  brf_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .ctl   (ctl)
  );

  // Store, positions and result register.
  brf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_req     (in_req),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .ctl        (ctl),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule
